// ----- rtl/scbc_pkg.sv -----
// Shared types, constants and byte helpers of the substitution chain block cipher.
// Depends on nothing; the lane, merge and top-level files use it by scoped names.
`default_nettype none

package scbc_pkg;

   localparam int BLOCK_BYTES = 16;
   localparam int LAST_BYTE   = BLOCK_BYTES - 1;
   localparam int BLOCK_BITS  = 8 * BLOCK_BYTES;
   localparam int LANE_W      = $clog2(BLOCK_BYTES);

   typedef enum logic [1:0] {
      ACT_LOAD_KEY  = 2'd0,
      ACT_LOAD_SBOX = 2'd1,
      ACT_ENCRYPT   = 2'd2,
      ACT_DECRYPT   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_RUN    = 2'd1,
      ST_FINISH = 2'd2
   } state_type;

   typedef logic [7:0] bytes_type [BLOCK_BYTES];

   typedef struct packed {
      logic key_we;
      logic sbox_we;
      logic key_re;
      logic sbox_re;
   } lane_ctrl_type;

   // Byte 0 sits in the most significant position of the block word.
   function automatic bytes_type unpack_block(input logic [BLOCK_BITS-1:0] blk);
      bytes_type b;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         b[i] = blk[BLOCK_BITS-1-8*i -: 8];
      end
      return b;
   endfunction

   function automatic logic [BLOCK_BITS-1:0] pack_block(input bytes_type b);
      logic [BLOCK_BITS-1:0] blk;
      blk = '0;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         blk[BLOCK_BITS-1-8*i -: 8] = b[i];
      end
      return blk;
   endfunction

   function automatic bytes_type xor_bytes(input bytes_type a, input bytes_type b);
      bytes_type c;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         c[i] = a[i] ^ b[i];
      end
      return c;
   endfunction

   // Running XOR from byte 0 upward as a four level prefix network, then the
   // last byte folds back into byte 0.
   function automatic bytes_type chain_forward(input bytes_type s);
      bytes_type t;
      bytes_type u;
      t = s;
      for (int d = 1; d < BLOCK_BYTES; d = d * 2) begin
         u = t;
         for (int i = 0; i < BLOCK_BYTES; i++) begin
            if (i >= d) begin
               t[i] = u[i] ^ u[i-d];
            end
         end
      end
      t[0] = t[0] ^ t[LAST_BYTE];
      return t;
   endfunction

   // Undoes chain_forward: every byte depends on at most three input bytes.
   function automatic bytes_type chain_inverse(input bytes_type b);
      bytes_type c;
      c[0] = b[0] ^ b[LAST_BYTE];
      c[1] = b[1] ^ c[0];
      for (int i = 2; i < BLOCK_BYTES; i++) begin
         c[i] = b[i] ^ b[i-1];
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/scbc_req_if.sv -----
// Request channel of the substitution chain block cipher: valid, ready and one item.
// Depends on nothing.
`default_nettype none

interface scbc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [2:0]  round_number;
   logic [7:0]  table_index;
   logic [7:0]  key_byte;
   logic [63:0] in_block_high;
   logic [63:0] in_block_low;

   modport source (output valid, action, round_number, table_index, key_byte,
                   in_block_high, in_block_low, input ready);
   modport sink   (input valid, action, round_number, table_index, key_byte,
                   in_block_high, in_block_low, output ready);
endinterface

`default_nettype wire

// ----- rtl/scbc_rsp_if.sv -----
// Response channel of the substitution chain block cipher: valid, ready and one result.
// Depends on nothing.
`default_nettype none

interface scbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_block_high;
   logic [63:0] out_block_low;
   logic        was_decrypt;

   modport source (output valid, out_block_high, out_block_low, was_decrypt,
                   input ready);
   modport sink   (input valid, out_block_high, out_block_low, was_decrypt,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/scbc_lane.sv -----
// One byte lane: its round key bytes and its own copy of the forward and inverse tables.
// Depends on scbc_pkg for the lane control struct.
`default_nettype none

module scbc_lane #(
   parameter int ROUNDS = 8
) (
   input  wire                                   clock,
   input  scbc_pkg::lane_ctrl_type               ctrl,
   input  wire [((ROUNDS > 1) ? $clog2(ROUNDS) : 1)-1:0] wr_round,
   input  wire [7:0]                             wr_index,
   input  wire [7:0]                             wr_value,
   input  wire [((ROUNDS > 1) ? $clog2(ROUNDS) : 1)-1:0] key_rd_round,
   input  wire [((ROUNDS > 1) ? $clog2(ROUNDS) : 1)-1:0] sbox_rd_round,
   input  wire [7:0]                             sbox_rd_addr,
   output logic [7:0]                            key_rd,
   output logic [7:0]                            fwd_rd,
   output logic [7:0]                            inv_rd
);

   logic [7:0] key_mem_ff [ROUNDS];
   logic [7:0] fwd_mem_ff [ROUNDS*256];
   logic [7:0] inv_mem_ff [ROUNDS*256];
   logic [7:0] key_rd_ff;
   logic [7:0] fwd_rd_ff;
   logic [7:0] inv_rd_ff;

   always_ff @(posedge clock) begin
      if (ctrl.key_we) begin
         key_mem_ff[wr_round] <= wr_value;
      end
      if (ctrl.sbox_we) begin
         fwd_mem_ff[{wr_round, wr_index}] <= wr_value;
         inv_mem_ff[{wr_round, wr_value}] <= wr_index;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.key_re) begin
         key_rd_ff <= key_mem_ff[key_rd_round];
      end
      if (ctrl.sbox_re) begin
         fwd_rd_ff <= fwd_mem_ff[{sbox_rd_round, sbox_rd_addr}];
         inv_rd_ff <= inv_mem_ff[{sbox_rd_round, sbox_rd_addr}];
      end
   end

   assign key_rd = key_rd_ff;
   assign fwd_rd = fwd_rd_ff;
   assign inv_rd = inv_rd_ff;

endmodule

`default_nettype wire

// ----- rtl/scbc_merge.sv -----
// Merging stage: combines the sixteen lane lookups into the next table addresses and the result.
// Depends on scbc_pkg for the byte array type and the chain functions.
`default_nettype none

module scbc_merge (
   input  scbc_pkg::bytes_type fwd_rd,
   input  scbc_pkg::bytes_type inv_rd,
   input  scbc_pkg::bytes_type key_rd,
   input  scbc_pkg::bytes_type in_bytes,
   input  wire                 first,
   input  wire                 decrypt,
   output scbc_pkg::bytes_type addr,
   output scbc_pkg::bytes_type result
);

   scbc_pkg::bytes_type fwd_state;
   scbc_pkg::bytes_type inv_state;

   always_comb begin
      // State after the round whose lookups just came back.
      fwd_state = scbc_pkg::chain_forward(fwd_rd);
      inv_state = scbc_pkg::xor_bytes(inv_rd, key_rd);
      if (decrypt) begin
         result = inv_state;
         addr   = scbc_pkg::chain_inverse(first ? in_bytes : inv_state);
      end else begin
         result = fwd_state;
         addr   = scbc_pkg::xor_bytes(first ? in_bytes : fwd_state, key_rd);
      end
   end

endmodule

`default_nettype wire

// ----- rtl/substitution_chain_block_cipher_unit.sv -----
// Top level of the substitution chain block cipher: control sequencer, sixteen lanes, merge.
// Depends on scbc_pkg, scbc_req_if, scbc_rsp_if, scbc_lane and scbc_merge.
//
// Usage: each request beat on req_chan is a table load or a block operation.
// A load beat (xor key byte or substitution entry) is taken while idle and
// gives no response. A substitution load writes the forward entry and the
// inverse entry at the written value in every lane at once. An encrypt or
// decrypt beat holds the block and then runs one round per cycle: all sixteen
// lanes look up their byte in their own table copy in parallel, and the merge
// stage forms the chained bytes that address the next round. The registered
// table read of each lane sets the pace of one round per cycle.
// The next request is taken once the result sits in the output register, so a
// new request is not taken while a block is still running its rounds or
// waiting to be loaded into the output register.
// The output register lets a new request in while a response waits. If the
// receiver still stalls when the next block finishes, that block waits in its
// final state with its lookups held until the output register frees up.
// Reset returns the sequencer to idle, holds the request ready low and drops
// the response valid; the key and substitution tables are not cleared and
// must be loaded before use.
`default_nettype none

module substitution_chain_block_cipher_unit #(
   parameter int ROUNDS = 8
) (
   input  wire        clock,
   input  wire        reset,
   scbc_req_if.sink   req_chan,
   scbc_rsp_if.source rsp_chan
);

   localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   scbc_pkg::state_type state_ff, state_in;
   logic [RW-1:0]       step_ff, step_in;
   logic                decrypt_ff, decrypt_in;
   logic [scbc_pkg::BLOCK_BITS-1:0] block_ff, block_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         out_high_ff, out_high_in;
   logic [63:0]         out_low_ff, out_low_in;
   logic                was_decrypt_ff, was_decrypt_in;

   logic          accept;
   logic          round_ok;
   logic          key_pos_ok;
   logic          step_last;
   logic          key_we;
   logic          sbox_we;
   logic          key_re;
   logic          sbox_re;
   logic          out_load;
   logic [RW-1:0] key_rd_round;
   logic [RW-1:0] sbox_rd_round;
   logic [RW-1:0] dec_round;
   logic [RW-1:0] wr_round;
   logic [scbc_pkg::BLOCK_BYTES-1:0] key_sel;

   scbc_pkg::bytes_type key_bytes;
   scbc_pkg::bytes_type fwd_bytes;
   scbc_pkg::bytes_type inv_bytes;
   scbc_pkg::bytes_type in_bytes;
   scbc_pkg::bytes_type addr_bytes;
   scbc_pkg::bytes_type result_bytes;
   logic [scbc_pkg::BLOCK_BITS-1:0] result_blk;

   assign accept     = req_chan.valid & req_chan.ready;
   assign round_ok   = int'(req_chan.round_number) < ROUNDS;
   assign key_pos_ok = int'(req_chan.table_index) < scbc_pkg::BLOCK_BYTES;
   assign wr_round   = RW'(req_chan.round_number);
   assign step_last  = (step_ff == RW'(ROUNDS - 1));
   assign dec_round  = RW'(ROUNDS - 1) - step_ff;
   assign in_bytes   = scbc_pkg::unpack_block(block_ff);
   assign result_blk = scbc_pkg::pack_block(result_bytes);

   // Sequencer: next state and lane strobes.
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      decrypt_in    = decrypt_ff;
      block_in      = block_ff;
      req_chan.ready = 1'b0;
      key_we        = 1'b0;
      sbox_we       = 1'b0;
      key_re        = 1'b0;
      sbox_re       = 1'b0;
      out_load      = 1'b0;
      key_rd_round  = '0;
      sbox_rd_round = '0;
      unique case (state_ff)
         scbc_pkg::ST_IDLE: begin
            req_chan.ready = ~reset;
            // Fetch round 0 keys so an encrypt can start its first lookup
            // in the cycle after it is taken.
            key_re = 1'b1;
            if (accept) begin
               unique case (scbc_pkg::action_type'(req_chan.action))
                  scbc_pkg::ACT_LOAD_KEY: begin
                     key_we = round_ok & key_pos_ok;
                  end
                  scbc_pkg::ACT_LOAD_SBOX: begin
                     sbox_we = round_ok;
                  end
                  scbc_pkg::ACT_ENCRYPT, scbc_pkg::ACT_DECRYPT: begin
                     decrypt_in = (scbc_pkg::action_type'(req_chan.action)
                                   == scbc_pkg::ACT_DECRYPT);
                     block_in   = {req_chan.in_block_high, req_chan.in_block_low};
                     step_in    = '0;
                     state_in   = scbc_pkg::ST_RUN;
                  end
                  default: begin
                     state_in = scbc_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         scbc_pkg::ST_RUN: begin
            key_re  = 1'b1;
            sbox_re = 1'b1;
            if (decrypt_ff) begin
               // Decrypt keys are applied after the inverse lookup of the
               // same round, so both are read together.
               sbox_rd_round = dec_round;
               key_rd_round  = dec_round;
            end else begin
               // Encrypt keys are applied before the lookup, one round ahead.
               sbox_rd_round = step_ff;
               key_rd_round  = step_last ? '0 : step_ff + RW'(1);
            end
            if (step_last) begin
               state_in = scbc_pkg::ST_FINISH;
            end else begin
               step_in = step_ff + RW'(1);
            end
         end
         scbc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               state_in = scbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scbc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in   = out_load | (rsp_valid_ff & ~rsp_chan.ready);
   assign out_high_in    = out_load ? result_blk[scbc_pkg::BLOCK_BITS-1 -: 64] : out_high_ff;
   assign out_low_in     = out_load ? result_blk[63:0] : out_low_ff;
   assign was_decrypt_in = out_load ? decrypt_ff : was_decrypt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scbc_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      decrypt_ff     <= decrypt_in;
      block_ff       <= block_in;
      out_high_ff    <= out_high_in;
      out_low_ff     <= out_low_in;
      was_decrypt_ff <= was_decrypt_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_block_high = out_high_ff;
   assign rsp_chan.out_block_low  = out_low_ff;
   assign rsp_chan.was_decrypt    = was_decrypt_ff;

   // Sixteen lanes, one per block byte. Only the lane named by a key load
   // takes the key byte; substitution loads go to every lane's table copy.
   for (genvar g = 0; g < scbc_pkg::BLOCK_BYTES; g++) begin : g_lane
      scbc_pkg::lane_ctrl_type lane_ctrl;

      assign key_sel[g] = key_we &
         (req_chan.table_index[scbc_pkg::LANE_W-1:0] == scbc_pkg::LANE_W'(g));
      assign lane_ctrl.key_we  = key_sel[g];
      assign lane_ctrl.sbox_we = sbox_we;
      assign lane_ctrl.key_re  = key_re;
      assign lane_ctrl.sbox_re = sbox_re;

      scbc_lane #(
         .ROUNDS(ROUNDS)
      ) u_lane (
         .clock        (clock),
         .ctrl         (lane_ctrl),
         .wr_round     (wr_round),
         .wr_index     (req_chan.table_index),
         .wr_value     (req_chan.key_byte),
         .key_rd_round (key_rd_round),
         .sbox_rd_round(sbox_rd_round),
         .sbox_rd_addr (addr_bytes[g]),
         .key_rd       (key_bytes[g]),
         .fwd_rd       (fwd_bytes[g]),
         .inv_rd       (inv_bytes[g])
      );
   end

   // The first round of a block addresses from the held input; later
   // rounds address from what the previous round's lookups produced.
   scbc_merge u_merge (
      .fwd_rd  (fwd_bytes),
      .inv_rd  (inv_bytes),
      .key_rd  (key_bytes),
      .in_bytes(in_bytes),
      .first   (step_ff == '0),
      .decrypt (decrypt_ff),
      .addr    (addr_bytes),
      .result  (result_bytes)
   );

`ifndef SYNTHESIS
   a_start_run: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.action == scbc_pkg::ACT_ENCRYPT ||
                  req_chan.action == scbc_pkg::ACT_DECRYPT))
      |=> (state_ff == scbc_pkg::ST_RUN && step_ff == '0))
      else $error("block operation did not start at round step zero");

   a_last_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scbc_pkg::ST_RUN && step_last) |=> (state_ff == scbc_pkg::ST_FINISH))
      else $error("last round did not move to finish");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_valid_ff && was_decrypt_ff == $past(decrypt_ff)))
      else $error("finished block not presented with its mode");

   a_key_one_lane: assert property (@(posedge clock) disable iff (reset)
      $onehot0(key_sel))
      else $error("key byte written to more than one lane");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != scbc_pkg::ST_IDLE) |-> !(key_we || sbox_we))
      else $error("table written while a block is in flight");
`endif

endmodule

`default_nettype wire
